### rtl/urds_pkg.sv
// Package for the ultrasonic ranging and display scan block: register indexes,
// phase encoding, result record and seven-segment helpers.
// No dependencies; compile before the interfaces and the core.
`default_nettype none

package urds_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_PERIOD    = 3'd0,
      CSR_MEASURE_PERIOD = 3'd1,
      CSR_BURST_HALF     = 3'd2,
      CSR_BURST_EDGES    = 3'd3,
      CSR_TIMEOUT        = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] SCAN_PERIOD_RST    = 16'd1000;
   localparam logic [7:0]  MEASURE_PERIOD_RST = 8'd200;
   localparam logic [7:0]  BURST_HALF_RST     = 8'd12;
   localparam logic [7:0]  BURST_EDGES_RST    = 8'd20;
   localparam logic [15:0] TIMEOUT_RST        = 16'd65535;

   // Measurement sequencer, one-hot
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_BURST = 3'b010,
      PH_ECHO  = 3'b100
   } phase_type;

   // 17/1000 cm per microsecond, tracked as quotient and remainder
   localparam logic [9:0] CM_STEP    = 10'd17;
   localparam logic [9:0] CM_DIVISOR = 10'd1000;
   localparam logic [7:0] DIST_MAX   = 8'd255;

   localparam logic [7:0] SEG_DASH  = 8'hbf;
   localparam logic [7:0] SEG_BLANK = 8'hff;

   typedef struct packed {
      logic       tx_level;
      logic [7:0] digit_select;
      logic [7:0] segment_pattern;
      logic       distance_valid;
      logic [7:0] distance_cm;
      logic       timed_out;
   } rsp_payload_type;

   // Active-low segments for one decimal digit
   function automatic logic [7:0] seg_digit(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'hc0;
         4'd1:    seg = 8'hf9;
         4'd2:    seg = 8'ha4;
         4'd3:    seg = 8'hb0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hf8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // Split an 8-bit value into hundreds, tens and ones ({h, t, o})
   function automatic logic [11:0] to_bcd(input logic [7:0] value);
      logic [3:0]  hundreds;
      logic [6:0]  rest;
      logic [14:0] scaled;
      logic [3:0]  tens;
      logic [3:0]  ones;
      if (value >= 8'd200) begin
         hundreds = 4'd2;
         rest     = 7'(value - 8'd200);
      end else if (value >= 8'd100) begin
         hundreds = 4'd1;
         rest     = 7'(value - 8'd100);
      end else begin
         hundreds = 4'd0;
         rest     = value[6:0];
      end
      // rest < 100: x*205 >> 11 equals x/10 here
      scaled = 15'(rest) * 15'd205;
      tens   = scaled[14:11];
      ones   = 4'(rest - 7'(tens) * 7'd10);
      return {hundreds, tens, ones};
   endfunction

endpackage : urds_pkg

`default_nettype wire

### rtl/urds_req_if.sv
// Input channel of the ranging block: one microsecond tick with the echo level.
// Stand-alone; no package needed.
`default_nettype none

interface urds_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface : urds_req_if

`default_nettype wire

### rtl/urds_rsp_if.sv
// Result channel of the ranging block: transmit level, display drive and distance.
// Stand-alone; no package needed.
`default_nettype none

interface urds_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_level;
   logic [7:0] digit_select;
   logic [7:0] segment_pattern;
   logic       distance_valid;
   logic [7:0] distance_cm;
   logic       timed_out;

   modport source (output valid, output tx_level, output digit_select,
                   output segment_pattern, output distance_valid,
                   output distance_cm, output timed_out, input ready);
   modport sink   (input valid, input tx_level, input digit_select,
                   input segment_pattern, input distance_valid,
                   input distance_cm, input timed_out, output ready);
endinterface : urds_rsp_if

`default_nettype wire

### rtl/ultrasonic_ranging_with_display_scan_core.sv
// Ultrasonic time-of-flight ranging with seven-segment display scan.
// An accepted tick beat's result is registered and appears in the cycle after.
// Throughput: one tick beat per cycle unless the sink stalls; the result
// register refills in the very cycle that the sink drains it.
// Reset: synchronous, active high; clears all counters and the sequencer and
// restores every configuration register to its default. No clearing pass.
`default_nettype none

module ultrasonic_ranging_with_display_scan_core #(
   parameter int DIGITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   urds_req_if.sink                             req_bus,
   urds_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_wr_en,
   input  wire logic [urds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [urds_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import urds_pkg::*;

   // Display geometry: the four rightmost positions carry dash, h, t, o
   localparam logic [3:0] DIGIT_COUNT = 4'(DIGITS);
   localparam logic [3:0] FIRST_POS   = 4'(DIGITS - 4);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] scan_period_ff;
   logic [7:0]  measure_period_ff;
   logic [7:0]  burst_half_ff;
   logic [7:0]  burst_edges_ff;
   logic [15:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff    <= SCAN_PERIOD_RST;
         measure_period_ff <= MEASURE_PERIOD_RST;
         burst_half_ff     <= BURST_HALF_RST;
         burst_edges_ff    <= BURST_EDGES_RST;
         timeout_ff        <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         // Writes to unused indexes fall through and are dropped
         unique case (csr_index_type'(csr_index))
            CSR_SCAN_PERIOD:    scan_period_ff    <= csr_wdata;
            CSR_MEASURE_PERIOD: measure_period_ff <= csr_wdata[7:0];
            CSR_BURST_HALF:     burst_half_ff     <= csr_wdata[7:0];
            CSR_BURST_EDGES:    burst_edges_ff    <= csr_wdata[7:0];
            CSR_TIMEOUT:        timeout_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake: the result register parts the two sides. A tick beat is
   // taken whenever the result register is empty or being drained.
   // ------------------------------------------------------------------
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   logic            req_fire;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // ------------------------------------------------------------------
   // Timing and sequencer state
   // ------------------------------------------------------------------
   logic [15:0] tick_count_ff,   tick_count_in;
   logic [7:0]  scan_count_ff,   scan_count_in;
   logic [2:0]  digit_index_ff,  digit_index_in;
   logic        measure_pending_ff, measure_pending_in;
   phase_type   phase_ff,        phase_in;
   logic [7:0]  half_count_ff,   half_count_in;
   logic [7:0]  edge_count_ff,   edge_count_in;
   logic [15:0] echo_count_ff,   echo_count_in;
   logic        tx_state_ff,     tx_state_in;
   logic [7:0]  last_distance_ff, last_distance_in;
   logic        last_timeout_ff, last_timeout_in;
   // Running floor(echo_count * 17 / 1000): quotient saturates at 255
   logic [7:0]  dist_q_ff,       dist_q_in;
   logic [9:0]  dist_rem_ff,     dist_rem_in;
   logic        done_in;

   // Scratch values of the update
   logic [15:0] tick_inc;
   logic [7:0]  scan_inc;
   logic [3:0]  digit_inc;
   logic        pending_mid;
   logic [7:0]  half_inc;
   logic [7:0]  edge_inc;
   logic [15:0] echo_inc;
   logic [9:0]  rem_step;

   always_comb begin
      tick_count_in      = tick_count_ff;
      scan_count_in      = scan_count_ff;
      digit_index_in     = digit_index_ff;
      phase_in           = phase_ff;
      half_count_in      = half_count_ff;
      edge_count_in      = edge_count_ff;
      echo_count_in      = echo_count_ff;
      tx_state_in        = tx_state_ff;
      last_distance_in   = last_distance_ff;
      last_timeout_in    = last_timeout_ff;
      dist_q_in          = dist_q_ff;
      dist_rem_in        = dist_rem_ff;
      done_in            = 1'b0;
      pending_mid        = measure_pending_ff;
      measure_pending_in = measure_pending_ff;

      tick_inc  = tick_count_ff + 16'd1;
      scan_inc  = scan_count_ff + 8'd1;
      digit_inc = {1'b0, digit_index_ff} + 4'd1;
      half_inc  = half_count_ff + 8'd1;
      edge_inc  = edge_count_ff + 8'd1;
      echo_inc  = echo_count_ff + 16'd1;
      rem_step  = dist_rem_ff + CM_STEP;

      // Display scan first; a finished scan period may arm a measurement
      tick_count_in = tick_inc;
      if (tick_inc >= scan_period_ff) begin
         tick_count_in = '0;
         // Wrap the 3-bit index, then again at the display width
         digit_index_in = (digit_inc[2:0] >= 3'(DIGIT_COUNT) && DIGIT_COUNT != 4'd8)
                        ? 3'd0 : digit_inc[2:0];
         scan_count_in  = scan_inc;
         if (scan_inc >= measure_period_ff) begin
            scan_count_in = '0;
            pending_mid   = 1'b1;
         end
      end
      measure_pending_in = pending_mid;

      // Measurement sequencer sees the trigger of this same tick
      unique case (phase_ff)
         PH_IDLE: begin
            tx_state_in = 1'b0;
            if (pending_mid) begin
               measure_pending_in = 1'b0;
               phase_in           = PH_BURST;
               half_count_in      = '0;
               edge_count_in      = '0;
            end
         end
         PH_BURST: begin
            half_count_in = half_inc;
            if (half_inc >= burst_half_ff) begin
               half_count_in = '0;
               tx_state_in   = !tx_state_ff;
               edge_count_in = edge_inc;
               if (edge_inc >= burst_edges_ff) begin
                  // Burst over: hold tx low and start timing the echo
                  phase_in      = PH_ECHO;
                  echo_count_in = '0;
                  dist_q_in     = '0;
                  dist_rem_in   = '0;
                  tx_state_in   = 1'b0;
               end
            end
         end
         PH_ECHO: begin
            tx_state_in = 1'b0;
            if (!req_bus.echo_level) begin
               last_distance_in = dist_q_ff;
               last_timeout_in  = 1'b0;
               done_in          = 1'b1;
               phase_in         = PH_IDLE;
            end else begin
               echo_count_in = echo_inc;
               // Advance the running quotient; once at 255 it stays there
               if (dist_q_ff != DIST_MAX) begin
                  if (rem_step >= CM_DIVISOR) begin
                     dist_rem_in = rem_step - CM_DIVISOR;
                     dist_q_in   = dist_q_ff + 8'd1;
                  end else begin
                     dist_rem_in = rem_step;
                  end
               end
               if (echo_inc >= timeout_ff) begin
                  last_distance_in = DIST_MAX;
                  last_timeout_in  = 1'b1;
                  done_in          = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Segment byte for the newly selected position
   logic [3:0]  disp_pos;
   logic [3:0]  disp_offset;
   logic [11:0] disp_bcd;
   logic [7:0]  seg_in;

   always_comb begin
      disp_pos    = {1'b0, digit_index_in};
      disp_offset = disp_pos - FIRST_POS;
      disp_bcd    = to_bcd(last_distance_in);
      seg_in      = SEG_BLANK;
      if (disp_pos >= FIRST_POS) begin
         unique case (disp_offset[1:0])
            2'd0: seg_in = SEG_DASH;
            2'd1: seg_in = seg_digit(disp_bcd[11:8]);
            2'd2: seg_in = seg_digit(disp_bcd[7:4]);
            2'd3: seg_in = seg_digit(disp_bcd[3:0]);
            default: seg_in = SEG_BLANK;
         endcase
      end
   end

   // Advance state only on an accepted tick beat
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff      <= '0;
         scan_count_ff      <= '0;
         digit_index_ff     <= '0;
         measure_pending_ff <= 1'b0;
         phase_ff           <= PH_IDLE;
         half_count_ff      <= '0;
         edge_count_ff      <= '0;
         echo_count_ff      <= '0;
         tx_state_ff        <= 1'b0;
         last_distance_ff   <= '0;
         last_timeout_ff    <= 1'b0;
         dist_q_ff          <= '0;
         dist_rem_ff        <= '0;
      end else if (req_fire) begin
         tick_count_ff      <= tick_count_in;
         scan_count_ff      <= scan_count_in;
         digit_index_ff     <= digit_index_in;
         measure_pending_ff <= measure_pending_in;
         phase_ff           <= phase_in;
         half_count_ff      <= half_count_in;
         edge_count_ff      <= edge_count_in;
         echo_count_ff      <= echo_count_in;
         tx_state_ff        <= tx_state_in;
         last_distance_ff   <= last_distance_in;
         last_timeout_ff    <= last_timeout_in;
         dist_q_ff          <= dist_q_in;
         dist_rem_ff        <= dist_rem_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: load on a tick beat, drop the valid once drained
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff.tx_level        <= tx_state_in;
         rsp_ff.digit_select    <= 8'b1 << digit_index_in;
         rsp_ff.segment_pattern <= seg_in;
         rsp_ff.distance_valid  <= done_in;
         rsp_ff.distance_cm     <= last_distance_in;
         rsp_ff.timed_out       <= last_timeout_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.tx_level        = rsp_ff.tx_level;
   assign rsp_bus.digit_select    = rsp_ff.digit_select;
   assign rsp_bus.segment_pattern = rsp_ff.segment_pattern;
   assign rsp_bus.distance_valid  = rsp_ff.distance_valid;
   assign rsp_bus.distance_cm     = rsp_ff.distance_cm;
   assign rsp_bus.timed_out       = rsp_ff.timed_out;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // The transmit pin only toggles inside a burst
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_BURST) |-> !tx_state_ff)
      else $error("tx high outside burst");

   // A timed-out measurement always reports the out-of-range distance
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.timed_out) |-> (rsp_ff.distance_cm == DIST_MAX))
      else $error("timeout without saturated distance");

   // The scan never selects a position beyond the display
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, digit_index_ff} < DIGIT_COUNT))
      else $error("digit index beyond display");

   // Every accepted tick leaves a result beat waiting
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("tick accepted without result");

endmodule : ultrasonic_ranging_with_display_scan_core

`default_nettype wire

### dv/ultrasonic_ranging_with_display_scan_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the ultrasonic ranging and display scan core: streams echo ticks,
// predicts every result beat in-house and compares field by field.
// Depends on urds_pkg, urds_req_if, urds_rsp_if and the core itself.

module ultrasonic_ranging_with_display_scan_core_tb;
   import urds_pkg::*;

   localparam int DISPLAY_DIGITS     = 8;
   localparam int FIRST_SHOWN        = DISPLAY_DIGITS - 4;
   localparam int STALL_LIMIT        = 5000;   // cycles with no beat on either side
   localparam int SETTLE_CYCLES      = 4;      // core result is registered; leave margin
   localparam int ROUND_TICKS        = 250;
   localparam int ROUND_MEASUREMENTS = 6;
   localparam int ROUND_SEGMENTS     = 5;

   typedef struct {
      logic [15:0] scan_period;
      logic [7:0]  measure_period;
      logic [7:0]  burst_half;
      logic [7:0]  burst_edges;
      logic [15:0] timeout;
   } ranging_settings_type;

   // Families of register settings used by the random rounds
   typedef enum int {
      CFG_SMALL,
      CFG_ZERO,
      CFG_MAX,
      CFG_SLOW_BURST,
      CFG_LONG_BURST
   } settings_kind_type;

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   urds_req_if req_if ();
   urds_rsp_if rsp_if ();

   ultrasonic_ranging_with_display_scan_core #(.DIGITS(DISPLAY_DIGITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Ranging predictor: own copy of the registers and of every counter in the core
   // ---------------------------------------------------------------------------------------
   ranging_settings_type cfg;
   logic [15:0] scan_tick;
   logic [7:0]  scans_done;
   logic [2:0]  lit_digit;
   logic        trigger_armed;
   phase_type   seq_phase;
   logic [7:0]  half_tick;
   logic [7:0]  edges_sent;
   logic [15:0] flight_ticks;
   logic        tx_pin;
   logic [7:0]  shown_cm;
   logic        shown_timeout;

   logic [7:0] glyph_of_digit [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                       8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

   rsp_payload_type expected_beats [$];
   logic            pending_echo [$];

   int ticks_queued;
   int ticks_taken;
   int beats_seen;
   int measurements_done;
   int timeouts_seen;
   int settings_applied;
   int mismatch_count;
   int idle_cycles;
   int tx_gap_pct;
   int rx_stall_pct;

   rsp_payload_type seen_beat;
   rsp_payload_type wanted_beat;

   int directed_flights [4] = '{0, 58, 59, 589};

   task automatic restore_defaults();
      cfg.scan_period    = SCAN_PERIOD_RST;
      cfg.measure_period = MEASURE_PERIOD_RST;
      cfg.burst_half     = BURST_HALF_RST;
      cfg.burst_edges    = BURST_EDGES_RST;
      cfg.timeout        = TIMEOUT_RST;
      scan_tick     = '0;
      scans_done    = '0;
      lit_digit     = '0;
      trigger_armed = 1'b0;
      seq_phase     = PH_IDLE;
      half_tick     = '0;
      edges_sent    = '0;
      flight_ticks  = '0;
      tx_pin        = 1'b0;
      shown_cm      = '0;
      shown_timeout = 1'b0;
   endtask

   // Left positions stay dark; the right four show dash, hundreds, tens, ones
   function automatic logic [7:0] glyph_at(input logic [2:0] pos);
      int place;
      place = int'(pos) - FIRST_SHOWN;
      case (place)
         0:       return SEG_DASH;
         1:       return glyph_of_digit[int'(shown_cm) / 100];
         2:       return glyph_of_digit[(int'(shown_cm) / 10) % 10];
         3:       return glyph_of_digit[int'(shown_cm) % 10];
         default: return SEG_BLANK;
      endcase
   endfunction

   // Advance the predictor by one microsecond tick and build the beat it should produce.
   // Scan timing goes first, then the measurement sequencer.
   function automatic rsp_payload_type advance_ranging(input logic echo);
      rsp_payload_type beat;
      int cm;
      beat.distance_valid = 1'b0;

      // Every counter is bumped before the compare, so a zero register behaves like one
      scan_tick = scan_tick + 16'd1;
      if (scan_tick >= cfg.scan_period) begin
         scan_tick = '0;
         lit_digit = lit_digit + 3'd1;
         if (int'(lit_digit) >= DISPLAY_DIGITS) lit_digit = '0;
         scans_done = scans_done + 8'd1;
         if (scans_done >= cfg.measure_period) begin
            scans_done    = '0;
            trigger_armed = 1'b1;  // stays armed through a running measurement
         end
      end

      case (seq_phase)
         PH_IDLE: begin
            tx_pin = 1'b0;
            if (trigger_armed) begin
               trigger_armed = 1'b0;
               seq_phase     = PH_BURST;
               half_tick     = '0;
               edges_sent    = '0;
            end
         end
         PH_BURST: begin
            half_tick = half_tick + 8'd1;
            if (half_tick >= cfg.burst_half) begin
               half_tick  = '0;
               tx_pin     = ~tx_pin;
               edges_sent = edges_sent + 8'd1;
               if (edges_sent >= cfg.burst_edges) begin
                  seq_phase    = PH_ECHO;
                  flight_ticks = '0;
                  tx_pin       = 1'b0;
               end
            end
         end
         default: begin
            tx_pin = 1'b0;
            if (!echo) begin
               // Echo back: convert the flight time, clip at the display maximum
               cm = int'(flight_ticks) * int'(CM_STEP) / int'(CM_DIVISOR);
               shown_cm            = (cm > int'(DIST_MAX)) ? DIST_MAX : 8'(cm);
               shown_timeout       = 1'b0;
               beat.distance_valid = 1'b1;
               seq_phase           = PH_IDLE;
               measurements_done++;
            end else begin
               flight_ticks = flight_ticks + 16'd1;
               if (flight_ticks >= cfg.timeout) begin
                  shown_cm            = DIST_MAX;
                  shown_timeout       = 1'b1;
                  beat.distance_valid = 1'b1;
                  seq_phase           = PH_IDLE;
                  measurements_done++;
                  timeouts_seen++;
               end
            end
         end
      endcase

      beat.tx_level        = tx_pin;
      beat.digit_select    = 8'b1 << lit_digit;
      beat.segment_pattern = glyph_at(lit_digit);
      beat.distance_cm     = shown_cm;
      beat.timed_out       = shown_timeout;
      return beat;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic compare_beat(input rsp_payload_type got, input rsp_payload_type want);
      if (got.tx_level !== want.tx_level)
         report_mismatch("tx_level", int'(got.tx_level), int'(want.tx_level));
      if (got.digit_select !== want.digit_select)
         report_mismatch("digit_select", int'(got.digit_select), int'(want.digit_select));
      if (got.segment_pattern !== want.segment_pattern)
         report_mismatch("segment_pattern", int'(got.segment_pattern),
                         int'(want.segment_pattern));
      if (got.distance_valid !== want.distance_valid)
         report_mismatch("distance_valid", int'(got.distance_valid), int'(want.distance_valid));
      if (got.distance_cm !== want.distance_cm)
         report_mismatch("distance_cm", int'(got.distance_cm), int'(want.distance_cm));
      if (got.timed_out !== want.timed_out)
         report_mismatch("timed_out", int'(got.timed_out), int'(want.timed_out));
   endtask

   // ---------------------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Tick driver: take the next echo level from the pending queue, hold it until accepted.
   // Each accepted beat runs the predictor once and files the beat it expects.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_beats.push_back(advance_ranging(req_if.echo_level));
            ticks_taken++;
         end
         // Only reload when the slot is free; a held beat keeps valid high untouched
         if (!req_if.valid || req_if.ready) begin
            if (pending_echo.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
               req_if.valid      <= 1'b1;
               req_if.echo_level <= pending_echo.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor: check each accepted beat against the oldest expectation, then
   // draw the next ready at random to stall the core.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_beat.tx_level        = rsp_if.tx_level;
            seen_beat.digit_select    = rsp_if.digit_select;
            seen_beat.segment_pattern = rsp_if.segment_pattern;
            seen_beat.distance_valid  = rsp_if.distance_valid;
            seen_beat.distance_cm     = rsp_if.distance_cm;
            seen_beat.timed_out       = rsp_if.timed_out;
            beats_seen++;
            if (expected_beats.size() == 0) begin
               report_mismatch("result beat with nothing expected", beats_seen, 0);
            end else begin
               wanted_beat = expected_beats.pop_front();
               compare_beat(seen_beat, wanted_beat);
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: give up when neither side moves a beat for too long
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, expected_beats.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic queue_tick(input logic echo);
      pending_echo.push_back(echo);
      ticks_queued++;
   endtask

   task automatic wait_ticks_taken();
      do @(negedge clock); while (ticks_taken != ticks_queued);
   endtask

   // Drain everything in flight, then let the core go quiet before touching registers
   task automatic settle();
      do @(negedge clock); while (ticks_taken != ticks_queued || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Junk in the top byte checks that narrow registers drop it
   function automatic logic [15:0] with_noise_byte(input logic [7:0] value);
      return {8'($urandom), value};
   endfunction

   // Drive one register beat; write enable stays high across back-to-back writes
   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SCAN_PERIOD:    cfg.scan_period    = value;
         CSR_MEASURE_PERIOD: cfg.measure_period = value[7:0];
         CSR_BURST_HALF:     cfg.burst_half     = value[7:0];
         CSR_BURST_EDGES:    cfg.burst_edges    = value[7:0];
         CSR_TIMEOUT:        cfg.timeout        = value;
         default:            ;  // unused index: the core must ignore it
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] scan, input logic [7:0] measure,
                                 input logic [7:0] half, input logic [7:0] edges,
                                 input logic [15:0] timeout);
      settle();
      // Hit an index past the register file first; it must leave everything alone
      write_setting(CSR_IDX_W'(int'(CSR_TIMEOUT) +
                    $urandom_range(1, 2 ** CSR_IDX_W - 1 - int'(CSR_TIMEOUT))),
                    16'($urandom));
      write_setting(CSR_SCAN_PERIOD, scan);
      write_setting(CSR_MEASURE_PERIOD, with_noise_byte(measure));
      write_setting(CSR_BURST_HALF, with_noise_byte(half));
      write_setting(CSR_BURST_EDGES, with_noise_byte(edges));
      write_setting(CSR_TIMEOUT, timeout);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      settings_applied++;
   endtask

   task automatic pick_settings(input settings_kind_type kind);
      case (kind)
         CFG_ZERO:       apply_settings(16'd0, 8'd0, 8'd0, 8'd0, 16'd0);
         CFG_MAX:        apply_settings(16'hffff, 8'hff, 8'hff, 8'hff, 16'hffff);
         CFG_SLOW_BURST: apply_settings(16'd1, 8'd1, 8'hff, 8'd2,
                                        16'($urandom_range(1, 300)));
         CFG_LONG_BURST: apply_settings(16'd2, 8'($urandom_range(1, 3)), 8'd1, 8'hff,
                                        16'hffff);
         default: apply_settings(16'($urandom_range(1, 4)), 8'($urandom_range(1, 6)),
                                 8'($urandom_range(1, 4)), 8'($urandom_range(1, 6)),
                                 $urandom_range(0, 1) ? 16'($urandom_range(1, 400))
                                                      : 16'($urandom_range(401, 65535)));
      endcase
   endtask

   // Echo line as a train of flights: a high stretch of random length closed by a low
   // stretch. Some flights are aimed at the timeout boundary; some lows run long as noise.
   task automatic stream_echo_runs(input int span);
      int left;
      int run;
      int pick;
      left = span;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            run = $urandom_range(0, 80);
         else if (pick < 90)
            run = $urandom_range(80, 400);
         else if (cfg.timeout <= 16'd2000)
            run = int'(cfg.timeout) + int'($urandom_range(0, 4)) - 2;
         else
            run = $urandom_range(0, 20);
         if (run < 0) run = 0;
         if (run > left) run = left;
         repeat (run) queue_tick(1'b1);
         left -= run;
         run = (pick % 10 == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
         if (run > left) run = left;
         repeat (run) queue_tick(1'b0);
         left -= run;
      end
   endtask

   // Step in lockstep until the echo window opens, then hold echo high for an exact
   // number of ticks and drop it, so the flight count is known precisely
   task automatic measure_echo(input int flight);
      while (seq_phase != PH_ECHO) begin
         queue_tick(1'b1);
         wait_ticks_taken();
      end
      repeat (flight) queue_tick(1'b1);
      queue_tick(1'b0);
      wait_ticks_taken();
   endtask

   // One random round: fresh settings per segment until enough ticks and measurements, or the segment limit
   task automatic random_round(input settings_kind_type first_kind);
      int start_ticks;
      int start_measurements;
      int seg;
      int draw;
      start_ticks        = ticks_queued;
      start_measurements = measurements_done;
      seg                = 0;
      while ((ticks_queued - start_ticks < ROUND_TICKS ||
              measurements_done - start_measurements < ROUND_MEASUREMENTS) &&
             seg < ROUND_SEGMENTS) begin
         draw = $urandom_range(0, 9);
         if (seg == 0)
            pick_settings(first_kind);
         else
            pick_settings(draw < 6 ? CFG_SMALL : settings_kind_type'(draw - 5));
         stream_echo_runs($urandom_range(50, 110));
         seg++;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.echo_level = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      reset             = 1'b1;
      ticks_queued      = 0;
      ticks_taken       = 0;
      beats_seen        = 0;
      measurements_done = 0;
      timeouts_seen     = 0;
      settings_applied  = 0;
      mismatch_count    = 0;
      idle_cycles       = 0;
      restore_defaults();

      // Lightly gapped sender, heavily stalled receiver first
      tx_gap_pct   = 15;
      rx_stall_pct = 79;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: a short stretch at the default scan rate
      stream_echo_runs(100);

      // Fast scan before any measurement: every position shows, with the dash and 000
      apply_settings(16'd1, MEASURE_PERIOD_RST, BURST_HALF_RST, BURST_EDGES_RST,
                     TIMEOUT_RST);
      stream_echo_runs(100);

      // Directed flights with everything at its fastest: zero echo time, either side of
      // the first centimetre and the first two-digit distance
      apply_settings(16'd1, 8'd1, 8'd1, 8'd1, 16'hffff);
      foreach (directed_flights[i]) measure_echo(directed_flights[i]);

      // Timeout just missed, just hit and well overrun
      apply_settings(16'd1, 8'd1, 8'd1, 8'd1, 16'd40);
      measure_echo(39);
      measure_echo(40);
      measure_echo(60);

      // Zero timeout still lets an immediate echo through; one tick of echo times out
      apply_settings(16'd1, 8'd1, 8'd1, 8'd1, 16'd0);
      measure_echo(0);
      measure_echo(5);
      apply_settings(16'd1, 8'd1, 8'd1, 8'd1, 16'd1);
      measure_echo(0);
      measure_echo(1);

      random_round(CFG_MAX);

      // Swap: gappy sender, mostly ready receiver
      settle();
      tx_gap_pct   = 79;
      rx_stall_pct = 15;
      random_round(CFG_ZERO);

      // Full rate on both sides
      settle();
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      random_round(CFG_LONG_BURST);

      // Drain, then give any stray beat time to show up
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0)
         report_mismatch("results never delivered", 0, expected_beats.size());

      $display("covered %0d ticks and %0d result beats over %0d register settings",
               ticks_taken, beats_seen, settings_applied);
      $display("%0d measurements completed, %0d ended on the echo timeout",
               measurements_done, timeouts_seen);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule : ultrasonic_ranging_with_display_scan_core_tb

### ultrasonic_ranging_with_display_scan_core.f
rtl/urds_pkg.sv
rtl/urds_req_if.sv
rtl/urds_rsp_if.sv
rtl/ultrasonic_ranging_with_display_scan_core.sv
dv/ultrasonic_ranging_with_display_scan_core_tb.sv
